### rtl/brhf_pkg.sv
package brhf_pkg;

  localparam int MAX_WINDOW    = 64;
  localparam int PRESSURE_BITS = 21;
  localparam int SLOT_W        = $clog2(MAX_WINDOW);
  localparam int FILL_W        = $clog2(MAX_WINDOW + 1);
  localparam int WSUM_W        = 27;
  localparam int BSUM_W        = 31;
  localparam int SEEN_W        = 10;
  localparam int HEIGHT_W      = 21;
  localparam int WSIZE_W       = 7;
  localparam int BCOUNT_W      = 10;
  localparam int GAIN_W        = 24;
  localparam int LIMIT_W       = 20;
  localparam int CFG_DATA_W    = 24;
  localparam int DIFF_W        = 28;
  localparam int PROD_W        = DIFF_W + GAIN_W;
  localparam int DIV_NUM_W     = 36;
  localparam int DIV_DEN_W     = 10;
  localparam int DIV_CNT_W     = 6;

  localparam logic [WSIZE_W-1:0]  WSIZE_RST  = 7'd25;
  localparam logic [BCOUNT_W-1:0] BCOUNT_RST = 10'd50;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 24'hF60000;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 20'd100000;

  typedef enum logic [1:0] {
    CFG_WINDOW_SIZE    = 2'd0,
    CFG_BASELINE_COUNT = 2'd1,
    CFG_HEIGHT_GAIN    = 2'd2,
    CFG_HEIGHT_LIMIT   = 2'd3
  } brhf_cfg_idx_t;

  typedef struct packed {
    logic load;
    logic update;
    logic base_div;
    logic base_store;
    logic diff;
    logic mul;
    logic hgt_div;
    logic emit;
  } brhf_cmd_t;

  typedef struct packed {
    logic base_now;
    logic base_ready;
    logic div_done;
    logic out_free;
    logic in_range;
  } brhf_sts_t;

endpackage

### rtl/brhf_if.sv
interface brhf_in_if
  import brhf_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [PRESSURE_BITS-1:0] pressure;

  modport source (output valid, output pressure, input ready);
  modport sink   (input valid, input pressure, output ready);
endinterface

interface brhf_out_if
  import brhf_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [HEIGHT_W-1:0] height_mm;

  modport source (output valid, output height_mm, input ready);
  modport sink   (input valid, input height_mm, output ready);
endinterface

### rtl/brhf_div.sv
module brhf_div
  import brhf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_NUM_W-1:0] quo,
  output logic                 done
);

  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DIV_NUM_W - 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 ge;

  // restoring division, one quotient bit a cycle
  assign rem_sh = {rem_r, num_r[DIV_NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = {num_r[DIV_NUM_W-2:0], ge};
      rem_nxt = ge ? DIV_DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_DEN_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign quo  = num_r;
  assign done = done_r;

endmodule

### rtl/brhf_dp.sv
module brhf_dp
  import brhf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  brhf_cmd_t                  cmd,
  output brhf_sts_t                  sts,
  input  logic [PRESSURE_BITS-1:0]   pressure,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [HEIGHT_W-1:0] out_height,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_idx,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  // configuration
  logic [WSIZE_W-1:0]  wsize_r;
  logic [BCOUNT_W-1:0] bcount_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [LIMIT_W-1:0]  limit_r;

  // window and baseline state
  logic [PRESSURE_BITS-1:0] mem [MAX_WINDOW];
  logic [PRESSURE_BITS-1:0] p_r;
  logic [PRESSURE_BITS-1:0] old_r;
  logic [SLOT_W-1:0]        slot_r;
  logic [FILL_W-1:0]        fill_r, fill_nxt;
  logic [WSUM_W-1:0]        wsum_r, wsum_nxt;
  logic [BSUM_W-1:0]        bsum_r;
  logic [SEEN_W-1:0]        seen_r;
  logic                     bready_r;
  logic [PRESSURE_BITS-1:0] bp_r;

  // height path
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     neg_r;
  logic                     oval_r;
  logic [HEIGHT_W-1:0]      ohgt_r;

  logic [FILL_W-1:0]        eff_w;
  logic [BCOUNT_W-1:0]      eff_cnt;
  logic [FILL_W:0]          fill_inc;
  logic                     drop;
  logic [WSUM_W:0]          wsum_add;
  logic [SEEN_W:0]          seen_inc;
  logic [BSUM_W:0]          base_num;
  logic [WSUM_W-1:0]        fill_bp;
  logic [PROD_W-1:0]        mag;
  logic [PROD_W-1:0]        mag_rnd;
  logic [DIV_NUM_W-1:0]     div_num;
  logic [DIV_DEN_W-1:0]     div_den;
  logic [DIV_NUM_W-1:0]     quo;
  logic                     div_done;
  logic [HEIGHT_W-1:0]      q_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r  <= WSIZE_RST;
      bcount_r <= BCOUNT_RST;
      gain_r   <= GAIN_RST;
      limit_r  <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (brhf_cfg_idx_t'(cfg_idx))
        CFG_WINDOW_SIZE:    wsize_r  <= cfg_data[WSIZE_W-1:0];
        CFG_BASELINE_COUNT: bcount_r <= cfg_data[BCOUNT_W-1:0];
        CFG_HEIGHT_GAIN:    gain_r   <= cfg_data[GAIN_W-1:0];
        CFG_HEIGHT_LIMIT:   limit_r  <= cfg_data[LIMIT_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (wsize_r == '0) begin
      eff_w = FILL_W'(1);
    end else if (FILL_W'(wsize_r) > FILL_W'(MAX_WINDOW)) begin
      eff_w = FILL_W'(MAX_WINDOW);
    end else begin
      eff_w = FILL_W'(wsize_r);
    end
  end

  assign eff_cnt  = (bcount_r == '0) ? BCOUNT_W'(1) : bcount_r;
  assign fill_inc = {1'b0, fill_r} + 1'b1;
  assign drop     = fill_inc > {1'b0, eff_w};
  assign fill_nxt = drop ? fill_r : fill_inc[FILL_W-1:0];
  assign wsum_add = {1'b0, wsum_r} + (WSUM_W+1)'(p_r);
  assign wsum_nxt = WSUM_W'(wsum_add - (drop ? (WSUM_W+1)'(old_r) : '0));
  assign seen_inc = {1'b0, seen_r} + 1'b1;
  assign base_num = {1'b0, bsum_r} + (BSUM_W+1)'(p_r) + (BSUM_W+1)'(eff_cnt >> 1);
  assign fill_bp  = WSUM_W'(fill_r * bp_r);

  // memory: oldest entry read on load, new sample written on update
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r   <= pressure;
      old_r <= mem[SLOT_W'(slot_r - fill_r[SLOT_W-1:0])];
    end
    if (cmd.update) begin
      mem[slot_r] <= p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      fill_r   <= '0;
      wsum_r   <= '0;
      bsum_r   <= '0;
      seen_r   <= '0;
      bready_r <= 1'b0;
      bp_r     <= '0;
    end else begin
      if (cmd.update) begin
        slot_r <= slot_r + 1'b1;
        fill_r <= fill_nxt;
        wsum_r <= wsum_nxt;
        if (!bready_r) begin
          bsum_r <= BSUM_W'({1'b0, bsum_r} + (BSUM_W+1)'(p_r));
          seen_r <= seen_inc[SEEN_W-1:0];
        end
      end
      if (cmd.base_store) begin
        bp_r     <= quo[PRESSURE_BITS-1:0];
        bready_r <= 1'b1;
      end
    end
  end

  // (window sum - fill * baseline) * gain, then magnitude with half-divisor rounding
  assign mag     = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign mag_rnd = mag + (PROD_W'(fill_r) << 15);

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      diff_r <= $signed({1'b0, wsum_r}) - $signed({1'b0, fill_bp});
    end
    if (cmd.mul) begin
      prod_r <= diff_r * $signed(gain_r);
    end
    if (cmd.hgt_div) begin
      neg_r <= prod_r[PROD_W-1];
    end
  end

  always_comb begin
    if (cmd.base_div) begin
      div_num = DIV_NUM_W'(base_num);
      div_den = DIV_DEN_W'(eff_cnt);
    end else begin
      div_num = mag_rnd[DIV_NUM_W+15:16];
      div_den = DIV_DEN_W'(fill_r);
    end
  end

  brhf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.base_div | cmd.hgt_div),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .done  (div_done)
  );

  assign q_lo = quo[HEIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else if (cmd.emit) begin
      oval_r <= 1'b1;
    end else if (out_ready) begin
      oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ohgt_r <= neg_r ? HEIGHT_W'(-q_lo) : q_lo;
    end
  end

  assign out_valid  = oval_r;
  assign out_height = $signed(ohgt_r);

  assign sts.base_now   = !bready_r && (seen_inc >= (SEEN_W+1)'(eff_cnt));
  assign sts.base_ready = bready_r;
  assign sts.div_done   = div_done;
  assign sts.out_free   = !oval_r || out_ready;
  assign sts.in_range   = quo < DIV_NUM_W'(limit_r);

endmodule

### rtl/brhf_ctrl.sv
module brhf_ctrl
  import brhf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  brhf_sts_t sts,
  output brhf_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_UPD  = 8'b0000_0010,
    S_BDIV = 8'b0000_0100,
    S_DIFF = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_RND  = 8'b0010_0000,
    S_HDIV = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        priority if (sts.base_now) begin
          cmd.base_div = 1'b1;
          state_nxt    = S_BDIV;
        end else if (sts.base_ready) begin
          state_nxt = S_DIFF;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_BDIV: begin
        if (sts.div_done) begin
          cmd.base_store = 1'b1;
          state_nxt      = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_RND;
      end
      S_RND: begin
        cmd.hgt_div = 1'b1;
        state_nxt   = S_HDIV;
      end
      S_HDIV: begin
        if (sts.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        priority if (!sts.in_range) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/baro_relative_height_filter_unit.sv
// Barometric relative-height filter. Each input beat carries one pressure sample in
// 0.1 Pa; the first baseline_count samples set the reference pressure, and each beat
// yields at most one output beat, the height in mm of the moving window average above
// that reference, emitted only while the reference is set and |height| < height_limit.
// Items are processed one at a time. Before the reference is set an item is only
// stored in the window; once it is set, each item also computes a height. The shared
// 36-step bit-serial divider is used once for the reference and once per height. An
// output register holds a finished beat, so the next item is taken while it waits. The
// user must write configuration only between items; the block does not enforce it.
module baro_relative_height_filter_unit
  import brhf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  brhf_in_if.sink               in_ch,
  brhf_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  brhf_cmd_t cmd;
  brhf_sts_t sts;

  brhf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  brhf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .pressure   (in_ch.pressure),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_height (out_ch.height_mm),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data)
  );

endmodule
